### hdl/kpsa_pkg.sv
// Package with shared types and constants of the keypad scanner.
`timescale 1ns / 1ps
`default_nettype none

package kpsa_pkg;

  localparam int unsigned NumRows = 4;
  localparam int unsigned NumCols = 4;

  // Held-key value that means no key is held.
  localparam logic [4:0] NoKey = 5'h1F;

  localparam logic [7:0] ThresholdReset = 8'd100;
  localparam logic [7:0] RewindReset    = 8'd33;

  typedef enum logic [1:0] {
    CFG_ENABLED   = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_REWIND    = 2'd2
  } cfg_idx_e;

  // What one row lane found in its column nibble.
  typedef struct packed {
    logic       hit;
    logic [1:0] col;
  } lane_t;

  // What the merge stage made of all rows.
  typedef struct packed {
    logic       found;
    logic [3:0] code;
  } merge_t;

  typedef struct packed {
    logic [3:0] key_code;
    logic       is_repeat;
  } report_t;

endpackage

`default_nettype wire

### hdl/kpsa_if.sv
// Handshake interfaces for scan tick items and key report items.
`timescale 1ns / 1ps
`default_nettype none

interface kpsa_tick_if;
  logic       valid;
  logic       ready;
  logic [3:0] row0_cols;
  logic [3:0] row1_cols;
  logic [3:0] row2_cols;
  logic [3:0] row3_cols;

  modport source (output valid, output row0_cols, output row1_cols,
                  output row2_cols, output row3_cols, input ready);
  modport sink   (input valid, input row0_cols, input row1_cols,
                  input row2_cols, input row3_cols, output ready);
endinterface

interface kpsa_key_if;
  logic       valid;
  logic       ready;
  logic [3:0] key_code;
  logic       is_repeat;

  modport source (output valid, output key_code, output is_repeat, input ready);
  modport sink   (input valid, input key_code, input is_repeat, output ready);
endinterface

`default_nettype wire

### hdl/kpsa_row_lane.sv
// One row lane: decodes an active-low column nibble into a hit and a column.
`timescale 1ns / 1ps
`default_nettype none

module kpsa_row_lane
  import kpsa_pkg::*;
(
  input  logic [3:0] cols_i,
  output lane_t      lane_o
);

  logic [3:0] pressed;

  assign pressed = ~cols_i;

  always_comb begin
    lane_o.hit = |pressed;
    // Several low columns fall back to column zero.
    unique case (pressed)
      4'b0010: lane_o.col = 2'd1;
      4'b0100: lane_o.col = 2'd2;
      4'b1000: lane_o.col = 2'd3;
      default: lane_o.col = 2'd0;
    endcase
  end

endmodule

`default_nettype wire

### hdl/kpsa_row_merge.sv
// Merge stage: the highest row with a hit wins and forms the key code.
`timescale 1ns / 1ps
`default_nettype none

module kpsa_row_merge
  import kpsa_pkg::*;
(
  input  lane_t  lanes_i [NumRows],
  output merge_t merge_o
);

  always_comb begin
    merge_o.found = 1'b0;
    merge_o.code  = '0;
    for (int r = 0; r < NumRows; r++) begin
      if (lanes_i[r].hit) begin
        merge_o.found = 1'b1;
        merge_o.code  = {r[1:0], lanes_i[r].col};
      end
    end
  end

endmodule

`default_nettype wire

### hdl/keypad_scan_autorepeat_core.sv
// Top level of the 4x4 keypad scanner with auto-repeat.
`timescale 1ns / 1ps
`default_nettype none

// Each tick item carries the column nibbles read for the four driven rows.
// Four row lanes decode their nibbles in parallel, a merge stage picks the
// highest pressed row, and the hold tracker decides within the same cycle
// whether the item reports a new press, a repeat, or nothing. A tick item is
// taken every cycle unless the tick side stalls; its report enters a two-entry
// output queue, which keeps the tick side accepting while a report waits. The
// tick side stalls only in a cycle where both queue entries hold reports and
// the key channel is not ready. The user must write configuration through the
// plain write port only while the block is idle; the block does not enforce
// this. Writes to unused indexes are ignored.
module keypad_scan_autorepeat_core
  import kpsa_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  kpsa_tick_if.sink       tick_i,
  kpsa_key_if.source      key_o
);

  logic       enabled_q;
  logic [7:0] threshold_q;
  logic [7:0] rewind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b0;
      threshold_q <= ThresholdReset;
      rewind_q    <= RewindReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLED:   enabled_q   <= cfg_data_i[0];
        CFG_THRESHOLD: threshold_q <= cfg_data_i;
        CFG_REWIND:    rewind_q    <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // Row lanes and merge.
  logic [3:0] row_cols [NumRows];
  lane_t      lanes    [NumRows];
  merge_t     merged;

  assign row_cols[0] = tick_i.row0_cols;
  assign row_cols[1] = tick_i.row1_cols;
  assign row_cols[2] = tick_i.row2_cols;
  assign row_cols[3] = tick_i.row3_cols;

  for (genvar r = 0; r < NumRows; r++) begin : g_lane
    kpsa_row_lane u_lane (
      .cols_i (row_cols[r]),
      .lane_o (lanes[r])
    );
  end

  kpsa_row_merge u_merge (
    .lanes_i (lanes),
    .merge_o (merged)
  );

  // Hold tracker.
  logic [4:0] held_q, held_d;
  logic [7:0] count_q, count_d;
  logic [7:0] count_inc;
  logic       in_fire;
  logic       res_valid;
  report_t    res;

  assign in_fire   = tick_i.valid && tick_i.ready;
  assign count_inc = count_q + 8'd1;

  always_comb begin
    held_d        = held_q;
    count_d       = count_q;
    res_valid     = 1'b0;
    res.key_code  = merged.code;
    res.is_repeat = 1'b0;
    if (in_fire && enabled_q) begin
      if (!merged.found) begin
        held_d = NoKey;
      end else if ({1'b0, merged.code} != held_q) begin
        held_d    = {1'b0, merged.code};
        count_d   = '0;
        res_valid = 1'b1;
      end else begin
        count_d = count_inc;
        if (count_inc == threshold_q) begin
          count_d       = count_inc - rewind_q;
          res_valid     = 1'b1;
          res.is_repeat = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= NoKey;
      count_q <= '0;
    end else begin
      held_q  <= held_d;
      count_q <= count_d;
    end
  end

  // Two-entry output queue.
  report_t    queue_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push, pop;

  assign pop          = key_o.valid && key_o.ready;
  assign push         = res_valid;
  assign tick_i.ready = (fill_q != 2'd2) || key_o.ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  assign key_o.valid     = (fill_q != 2'd0);
  assign key_o.key_code  = queue_q[rd_ptr_q].key_code;
  assign key_o.is_repeat = queue_q[rd_ptr_q].is_repeat;

endmodule

`default_nettype wire

### tb/tb_keypad_scan_autorepeat_core.sv
// Self-checking testbench for the keypad scanner core with auto-repeat.
`timescale 1ns / 1ps

module tb_keypad_scan_autorepeat_core
  import kpsa_pkg::*;
();

  typedef logic [NumRows-1:0][NumCols-1:0] scan_t;

  localparam scan_t       NoPress    = '1;
  localparam logic [1:0]  CfgUnused  = 2'd3;
  localparam int unsigned IdleTail   = 4;
  localparam int unsigned CycleLimit = 1_000_000;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [7:0] cfg_data;

  kpsa_tick_if tick_bus ();
  kpsa_key_if  key_bus ();

  keypad_scan_autorepeat_core u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .tick_i    (tick_bus),
    .key_o     (key_bus)
  );

  // Our own copy of the scanner registers and hold tracker.
  logic       cfg_enabled   = 1'b0;
  logic [7:0] cfg_threshold = ThresholdReset;
  logic [7:0] cfg_rewind    = RewindReset;
  logic [4:0] held_key      = NoKey;
  logic [7:0] hold_count    = '0;

  report_t     due_reports[$];
  int unsigned mismatches      = 0;
  int unsigned cycle_count     = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned sink_wait       = 0;
  bit          tick_gaps       = 1'b0;
  bit          sink_stalls     = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_keypad_scan_autorepeat_core: FAIL");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 75) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // Key report receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_off_cycles != 0) begin
        sink_wait = hold_off_cycles;
        hold_off_cycles = 0;
      end else if (sink_wait == 0 && sink_stalls && $urandom_range(99, 0) < 20) begin
        sink_wait = gap_len();
      end
      if (sink_wait != 0) begin
        key_bus.ready <= 1'b0;
        sink_wait--;
      end else begin
        key_bus.ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Outputs are sampled mid-cycle, where nothing is changing.
  always @(negedge clk_i) begin : check_reports
    report_t due;
    if (rst_ni && key_bus.valid && key_bus.ready) begin
      if (due_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected report key %0d repeat %0b",
                                  key_bus.key_code, key_bus.is_repeat));
      end else begin
        due = due_reports.pop_front();
        if (key_bus.key_code !== due.key_code)
          report_mismatch($sformatf("key_code %0d, expected %0d",
                                    key_bus.key_code, due.key_code));
        if (key_bus.is_repeat !== due.is_repeat)
          report_mismatch($sformatf("is_repeat %0b, expected %0b for key %0d",
                                    key_bus.is_repeat, due.is_repeat, due.key_code));
      end
    end
  end

  // Decodes one scan tick and advances the hold tracker.
  function automatic void predict_report(input scan_t scan);
    logic [3:0] low_cols;
    logic [3:0] code;
    logic [1:0] col;
    logic       found;
    report_t    rpt;
    if (!cfg_enabled) return;
    found = 1'b0;
    code  = '0;
    for (int r = 0; r < NumRows; r++) begin
      low_cols = ~scan[r];
      if (low_cols != 0) begin
        found = 1'b1;
        case (low_cols)
          4'b0010: col = 2'd1;
          4'b0100: col = 2'd2;
          4'b1000: col = 2'd3;
          default: col = 2'd0;
        endcase
        code = {2'(r), col};
      end
    end
    if (!found) begin
      held_key = NoKey;
      return;
    end
    if ({1'b0, code} != held_key) begin
      held_key   = {1'b0, code};
      hold_count = '0;
      rpt.key_code  = code;
      rpt.is_repeat = 1'b0;
      due_reports.push_back(rpt);
    end else begin
      hold_count = hold_count + 8'd1;
      if (hold_count == cfg_threshold) begin
        hold_count    = hold_count - cfg_rewind;
        rpt.key_code  = code;
        rpt.is_repeat = 1'b1;
        due_reports.push_back(rpt);
      end
    end
  endfunction

  // Rows above the pressed one read idle; rows below carry random levels.
  function automatic scan_t key_scan(input int unsigned row, input logic [3:0] low_mask);
    scan_t scan;
    for (int r = 0; r < NumRows; r++) begin
      if (r < row) scan[r] = 4'($urandom);
      else if (r == row) scan[r] = ~low_mask;
      else scan[r] = 4'hF;
    end
    return scan;
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_tick(input scan_t scan);
    int unsigned gap;
    gap = 0;
    if (tick_gaps && $urandom_range(99, 0) < 30) gap = gap_len();
    if (gap != 0) begin
      tick_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_bus.valid     <= 1'b1;
    tick_bus.row0_cols <= scan[0];
    tick_bus.row1_cols <= scan[1];
    tick_bus.row2_cols <= scan[2];
    tick_bus.row3_cols <= scan[3];
    do @(negedge clk_i); while (!tick_bus.ready);
    @(posedge clk_i);
    predict_report(scan);
  endtask

  task automatic hold_press(input int unsigned row, input logic [3:0] low_mask,
                            input int unsigned count);
    repeat (count) send_tick(key_scan(row, low_mask));
  endtask

  // Stops offering items and waits until every report is in and the core is quiet.
  task automatic settle_idle();
    tick_bus.valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk_i);
    repeat (IdleTail) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ENABLED:   cfg_enabled   = data[0];
      CFG_THRESHOLD: cfg_threshold = data;
      CFG_REWIND:    cfg_rewind    = data;
      default: ;
    endcase
  endtask

  task automatic test_disabled_after_reset();
    write_reg(CfgUnused, 8'hFF);
    repeat (4) send_tick(key_scan($urandom_range(3, 0), 4'b0001 << $urandom_range(3, 0)));
    send_tick(NoPress);
    send_tick('0);
    settle_idle();
  endtask

  task automatic test_decode_directed();
    write_reg(CFG_THRESHOLD, 8'd2);
    write_reg(CFG_REWIND, 8'd1);
    write_reg(CFG_ENABLED, 8'hFF);
    send_tick(NoPress);
    send_tick('0);
    send_tick(key_scan(0, 4'b0001));
    send_tick(key_scan(0, 4'b1000));
    send_tick(key_scan(1, 4'b0011));
    // Several low columns give column 0, so this is the same key held.
    send_tick(key_scan(1, 4'b0001));
    send_tick(key_scan(1, 4'b1111));
    send_tick(key_scan(1, 4'b0001));
    send_tick(NoPress);
    send_tick(key_scan(1, 4'b0001));
    send_tick({4'hF, 4'b1011, 4'hF, 4'h0});
    hold_press(3, 4'b1000, 4);
    send_tick(key_scan(2, 4'b0010));
    send_tick(key_scan(3, 4'b0110));
    send_tick(key_scan(3, 4'b0001));
    send_tick(NoPress);
    settle_idle();
  endtask

  task automatic test_counter_extremes();
    logic [7:0]  thresholds [4] = '{8'd1, 8'd255, 8'd0, 8'd5};
    logic [7:0]  rewinds    [4] = '{8'd1, 8'd254, 8'd0, 8'd255};
    int unsigned lengths    [4] = '{6, 260, 258, 265};
    for (int i = 0; i < 4; i++) begin
      tick_gaps   = (i != 1);
      sink_stalls = (i != 2);
      write_reg(CFG_THRESHOLD, thresholds[i]);
      write_reg(CFG_REWIND, rewinds[i]);
      hold_press($urandom_range(3, 0), 4'b0001 << $urandom_range(3, 0), lengths[i]);
      send_tick(NoPress);
      settle_idle();
    end
  endtask

  task automatic test_disable_keeps_state();
    tick_gaps   = 1'b1;
    sink_stalls = 1'b1;
    write_reg(CFG_THRESHOLD, 8'd4);
    write_reg(CFG_REWIND, 8'd2);
    hold_press(2, 4'b0100, 3);
    settle_idle();
    write_reg(CFG_ENABLED, 8'hFE);
    send_tick(NoPress);
    send_tick(key_scan(0, 4'b0010));
    send_tick(scan_t'($urandom_range(16'hFFFF, 0)));
    send_tick(NoPress);
    send_tick(key_scan(3, 4'b1111));
    send_tick('0);
    settle_idle();
    write_reg(CFG_ENABLED, 8'h01);
    write_reg(CfgUnused, 8'h00);
    hold_press(2, 4'b0100, 3);
    send_tick(NoPress);
    settle_idle();
  endtask

  task automatic test_backpressure();
    tick_gaps   = 1'b0;
    sink_stalls = 1'b0;
    write_reg(CFG_THRESHOLD, 8'd1);
    write_reg(CFG_REWIND, 8'd1);
    // With a threshold of one, every tick of a held key produces a report.
    hold_off_cycles = 200;
    hold_press(1, 4'b0100, 60);
    settle_idle();
    sink_stalls = 1'b1;
    hold_off_cycles = 150;
    for (int i = 0; i < 40; i++)
      send_tick(key_scan(i % NumRows, 4'b0001 << $urandom_range(3, 0)));
    send_tick(NoPress);
    settle_idle();
  endtask

  task automatic test_random_traffic();
    logic [7:0]  thresholds [6] = '{8'd8, 8'd3, 8'd20, 8'd1, 8'd2, 8'd0};
    logic [7:0]  rewinds    [6] = '{8'd3, 8'd1, 8'd19, 8'd1, 8'd200, 8'd0};
    int unsigned sent;
    int unsigned pick;
    int unsigned count;
    int unsigned row;
    int unsigned thr;
    logic [3:0]  mask;
    for (int p = 0; p < 6; p++) begin
      tick_gaps   = (p != 1 && p != 4);
      sink_stalls = (p != 1 && p != 3);
      if (p == 5) begin
        thresholds[p] = 8'($urandom_range(12, 1));
        rewinds[p]    = 8'($urandom_range(255, 0));
      end
      write_reg(CFG_THRESHOLD, thresholds[p]);
      write_reg(CFG_REWIND, rewinds[p]);
      thr  = thresholds[p];
      sent = 0;
      while (sent < 130) begin
        pick = $urandom_range(99, 0);
        if (pick < 70) begin
          row  = $urandom_range(3, 0);
          mask = ($urandom_range(3, 0) != 0) ? 4'b0001 << $urandom_range(3, 0)
                                             : 4'($urandom_range(15, 1));
          count = ($urandom_range(9, 0) < 7) ? $urandom_range(thr + 2, 1)
                                             : $urandom_range(3 * thr + 3, 1);
          hold_press(row, mask, count);
          sent += count;
        end else if (pick < 85) begin
          count = $urandom_range(3, 1);
          repeat (count) send_tick(NoPress);
          sent += count;
        end else begin
          send_tick(scan_t'($urandom_range(16'hFFFF, 0)));
          sent++;
        end
      end
      settle_idle();
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_ENABLED;
    cfg_data           = '0;
    tick_bus.valid     = 1'b0;
    tick_bus.row0_cols = 4'hF;
    tick_bus.row1_cols = 4'hF;
    tick_bus.row2_cols = 4'hF;
    tick_bus.row3_cols = 4'hF;
    key_bus.ready      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_disabled_after_reset();
    test_decode_directed();
    test_counter_extremes();
    test_disable_keeps_state();
    test_backpressure();
    test_random_traffic();
    settle_idle();

    if (mismatches == 0) begin
      $display("tb_keypad_scan_autorepeat_core: PASS");
    end else begin
      $display("tb_keypad_scan_autorepeat_core: FAIL");
    end
    $finish;
  end

endmodule
